>>> src/wpdh_pkg.sv
// wpdh_pkg: constants, codes and types for the weighted pair-distance histogram.
// No dependencies.
`default_nettype none
package wpdh_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int NUM_BINS   = 32;
    localparam int BIN_AW     = 5;
    localparam int SUM_W      = 48;
    localparam int SQ_STEPS   = 17;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_AUTO  = 3'd1;
    localparam logic [2:0] OP_REF   = 3'd2;
    localparam logic [2:0] OP_CROSS = 3'd3;
    localparam logic [2:0] OP_DUMP  = 3'd4;

    localparam logic [2:0] CFG_DIST_MIN = 3'd0;
    localparam logic [2:0] CFG_DIST_MAX = 3'd1;
    localparam logic [2:0] CFG_STEP_REC = 3'd2;
    localparam logic [2:0] CFG_BINS     = 3'd3;
    localparam logic [2:0] CFG_DIMS     = 3'd4;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [15:0]        w;
    } t_point;
endpackage
`default_nettype wire

>>> src/weighted_pair_distance_histogram_top.sv
// Weighted pair-distance histogram: point store memory, pair pipeline with
// staged square root, histogram memory with read-modify-write. Uses wpdh_pkg.
//
// channel   dir  handshake           payload
// input     in   i_valid / o_ready   i_operation, i_coord_x/y/z, i_point_weight
// result    out  o_valid / i_ready   o_bin_number, o_bin_sum, o_last_bin
// config    in   i_cfg_we            i_cfg_idx, i_cfg_data
//
// Auto and cross words pair the word's point with each point already stored,
// one pair a cycle from the point memory read port, then drain the pipeline.
// Clear and reference words need no pairing pass. A dump steps each bin through
// the histogram memory read, the output register and a wait for i_ready.
// Reset is synchronous; histogram entries are marked empty by flip-flops, so
// no clearing pass is needed. A stalled output holds the dump sequencer.
`default_nettype none
module weighted_pair_distance_histogram_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_operation,
    input  wire logic signed [15:0] i_coord_x,
    input  wire logic signed [15:0] i_coord_y,
    input  wire logic signed [15:0] i_coord_z,
    input  wire logic [15:0]        i_point_weight,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [4:0]              o_bin_number,
    output logic [47:0]             o_bin_sum,
    output logic                    o_last_bin,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data
);
    localparam int NPV = 26;
    localparam int CW  = wpdh_pkg::PT_AW + 1;

    typedef enum logic [2:0] {ST_IDLE, ST_PAIR, ST_DRAIN, ST_DRD, ST_DLD, ST_DWT} t_state;

    t_state r_state;
    logic [16:0] r_dmin, r_dmax;
    logic [23:0] r_step;
    logic [5:0]  r_bins;
    logic [1:0]  r_dims;
    logic [33:0] r_lo2, r_hi2;

    wpdh_pkg::t_point r_pt;
    wpdh_pkg::t_point r_mem [wpdh_pkg::MAX_POINTS];
    wpdh_pkg::t_point r_q;
    logic [CW-1:0] r_count, r_npair, r_i;
    logic [wpdh_pkg::BIN_AW-1:0] r_k;
    logic [NPV-1:0] r_pv;

    logic [wpdh_pkg::SUM_W-1:0] r_hmem [wpdh_pkg::NUM_BINS];
    logic [wpdh_pkg::SUM_W-1:0] r_hq;
    logic [wpdh_pkg::NUM_BINS-1:0] r_hv;

    logic accept, do_store;
    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign do_store = accept && (i_operation == wpdh_pkg::OP_AUTO ||
                      i_operation == wpdh_pkg::OP_REF) && (r_count < CW'(wpdh_pkg::MAX_POINTS));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmin <= '0;
            r_dmax <= 17'h1FFFF;
            r_step <= 24'd65536;
            r_bins <= 6'd32;
            r_dims <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wpdh_pkg::CFG_DIST_MIN: r_dmin <= i_cfg_data[16:0];
                wpdh_pkg::CFG_DIST_MAX: r_dmax <= i_cfg_data[16:0];
                wpdh_pkg::CFG_STEP_REC: r_step <= i_cfg_data;
                wpdh_pkg::CFG_BINS:     r_bins <= i_cfg_data[5:0];
                wpdh_pkg::CFG_DIMS:     r_dims <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo2 <= 34'(r_dmin) * 34'(r_dmin);
        r_hi2 <= 34'(r_dmax) * 34'(r_dmax);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_npair   <= '0;
            r_i       <= '0;
            r_k       <= '0;
            o_valid   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_pt <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z, w: i_point_weight};
                        r_npair <= r_count;
                        r_i     <= '0;
                        if (do_store) r_count <= r_count + 1'b1;
                        case (i_operation)
                            wpdh_pkg::OP_CLEAR: r_count <= '0;
                            wpdh_pkg::OP_AUTO, wpdh_pkg::OP_CROSS: begin
                                if (r_count != '0) r_state <= ST_PAIR;
                            end
                            wpdh_pkg::OP_DUMP: begin
                                r_k     <= '0;
                                r_state <= ST_DRD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PAIR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == r_npair - 1'b1) r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (r_pv == '0) r_state <= ST_IDLE;
                end
                ST_DRD: r_state <= ST_DLD;
                ST_DLD: begin
                    o_valid      <= 1'b1;
                    o_bin_number <= r_k;
                    o_bin_sum    <= r_hv[r_k] ? r_hq : '0;
                    o_last_bin   <= (r_k == wpdh_pkg::BIN_AW'(wpdh_pkg::NUM_BINS - 1));
                    r_state      <= ST_DWT;
                end
                ST_DWT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last_bin) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_DRD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (do_store)
            r_mem[r_count[wpdh_pkg::PT_AW-1:0]] <=
                '{x: i_coord_x, y: i_coord_y, z: i_coord_z, w: i_point_weight};
        r_q <= r_mem[r_i[wpdh_pkg::PT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= '0;
        else          r_pv <= {r_pv[NPV-2:0], (r_state == ST_PAIR)};
    end

    // distance stages
    logic signed [16:0] dx, dy, dz;
    logic [16:0] mx, my, mz;
    logic [15:0] r_ax, r_ay, r_az, r_w1, r_w2;
    logic [31:0] r_sx, r_sy, r_sz, r_p2, r_p3;
    logic [33:0] r_d2;

    assign dx = 17'(r_pt.x) - 17'(r_q.x);
    assign dy = 17'(r_pt.y) - 17'(r_q.y);
    assign dz = 17'(r_pt.z) - 17'(r_q.z);
    assign mx = dx[16] ? 17'(-dx) : 17'(dx);
    assign my = dy[16] ? 17'(-dy) : 17'(dy);
    assign mz = dz[16] ? 17'(-dz) : 17'(dz);

    always_ff @(posedge i_clk) begin
        r_ax <= mx[15:0];
        r_ay <= r_dims[1] ? my[15:0] : 16'd0;
        r_az <= (r_dims == 2'd3) ? mz[15:0] : 16'd0;
        r_w1 <= r_pt.w;
        r_w2 <= r_q.w;
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;
        r_sz <= r_az * r_az;
        r_p2 <= r_w1 * r_w2;
        r_d2 <= 34'(r_sx) + 34'(r_sy) + 34'(r_sz);
        r_p3 <= r_p2;
    end

    // square root, one result bit a stage
    logic [33:0] r_sv  [wpdh_pkg::SQ_STEPS+1];
    logic [34:0] r_sr  [wpdh_pkg::SQ_STEPS+1];
    logic        r_sok [wpdh_pkg::SQ_STEPS+1];
    logic [31:0] r_sp  [wpdh_pkg::SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        r_sv[0]  <= r_d2;
        r_sr[0]  <= '0;
        r_sok[0] <= (r_d2 > r_lo2) && (r_d2 < r_hi2);
        r_sp[0]  <= r_p3;
    end

    for (genvar k = 0; k < wpdh_pkg::SQ_STEPS; k++) begin : g_sq
        localparam logic [35:0] BIT = 36'd1 << (32 - 2 * k);
        logic [35:0] trial;
        assign trial = 36'(r_sr[k]) + BIT;
        always_ff @(posedge i_clk) begin
            if ({2'b00, r_sv[k]} >= trial) begin
                r_sv[k+1] <= 34'({2'b00, r_sv[k]} - trial);
                r_sr[k+1] <= 35'(36'(r_sr[k] >> 1) + BIT);
            end else begin
                r_sv[k+1] <= r_sv[k];
                r_sr[k+1] <= r_sr[k] >> 1;
            end
            r_sok[k+1] <= r_sok[k];
            r_sp[k+1]  <= r_sp[k];
        end
    end

    // bin index
    logic [16:0] root;
    logic [16:0] r_diff;
    logic        r_dok, r_mok, r_bok, r_hok;
    logic [31:0] r_dp, r_mp, r_bp, r_hp;
    logic [40:0] r_mul;
    logic [24:0] bin_full;
    logic [5:0]  active;
    logic [wpdh_pkg::BIN_AW-1:0] r_bbin, r_hbin;

    assign root     = r_sr[wpdh_pkg::SQ_STEPS][16:0];
    assign bin_full = r_mul[40:16];
    assign active   = (r_bins > 6'(wpdh_pkg::NUM_BINS)) ? 6'(wpdh_pkg::NUM_BINS) : r_bins;

    always_ff @(posedge i_clk) begin
        r_diff <= root - r_dmin;
        r_dok  <= r_sok[wpdh_pkg::SQ_STEPS] && (root >= r_dmin);
        r_dp   <= r_sp[wpdh_pkg::SQ_STEPS];
        r_mul  <= r_diff * r_step;
        r_mok  <= r_dok;
        r_mp   <= r_dp;
        r_bbin <= bin_full[wpdh_pkg::BIN_AW-1:0];
        r_bok  <= r_mok && (bin_full < 25'(active));
        r_bp   <= r_mp;
        r_hbin <= r_bbin;
        r_hok  <= r_bok;
        r_hp   <= r_bp;
    end

    // histogram read-modify-write with one-deep forwarding
    logic [wpdh_pkg::BIN_AW-1:0] hraddr;
    logic [wpdh_pkg::SUM_W-1:0]  old_sum, new_sum, r_wdata;
    logic [wpdh_pkg::SUM_W:0]    sum;
    logic [wpdh_pkg::BIN_AW-1:0] r_wbin;
    logic hwe, r_wfw;

    assign hraddr  = (r_state == ST_DRD) ? r_k : r_bbin;
    assign hwe     = r_pv[NPV-1] && r_hok;
    assign old_sum = (r_wfw && r_wbin == r_hbin) ? r_wdata : (r_hv[r_hbin] ? r_hq : '0);
    assign sum     = {1'b0, old_sum} + (wpdh_pkg::SUM_W + 1)'(r_hp);
    assign new_sum = sum[wpdh_pkg::SUM_W] ? '1 : sum[wpdh_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (hwe) r_hmem[r_hbin] <= new_sum;
        r_hq    <= r_hmem[hraddr];
        r_wbin  <= r_hbin;
        r_wdata <= new_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= '0;
            r_wfw <= 1'b0;
        end else begin
            r_wfw <= hwe;
            if (accept && i_operation == wpdh_pkg::OP_CLEAR) r_hv <= '0;
            else if (hwe) r_hv[r_hbin] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> tb/weighted_pair_distance_histogram_top_tb.sv
// Testbench for weighted_pair_distance_histogram_top: directed table, then random
// point traffic under configuration phases, checked against a built-in histogram
// predictor. Depends on wpdh_pkg and the top-level RTL.
`timescale 1ns / 1ps
module weighted_pair_distance_histogram_top_tb;
    import wpdh_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] x, y, z, w;
        bit          zero_dump;
    } t_row;

    typedef struct {
        logic [4:0]  bin;
        logic [47:0] sum;
        logic        last;
    } t_bin_word;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic [2:0]         i_operation = '0;
    logic signed [15:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [15:0]        i_point_weight = '0;
    logic               o_valid;
    logic               i_ready = 0;
    logic [4:0]         o_bin_number;
    logic [47:0]        o_bin_sum;
    logic               o_last_bin;
    logic               i_cfg_we = 0;
    logic [2:0]         i_cfg_idx = '0;
    logic [23:0]        i_cfg_data = '0;

    weighted_pair_distance_histogram_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [16:0] min_dist = 0, max_dist = 131071;
    logic [23:0] step_rec = 65536;
    logic [5:0]  bins_act = 32;
    logic [1:0]  dims = 3;
    logic signed [15:0] pt_x [MAX_POINTS];
    logic signed [15:0] pt_y [MAX_POINTS];
    logic signed [15:0] pt_z [MAX_POINTS];
    logic [15:0]        pt_w [MAX_POINTS];
    int unsigned        pt_count = 0;
    longint unsigned    hist [NUM_BINS];
    t_bin_word          bins_due [$];

    int errors = 0;
    int tx_idle = 0, rx_idle = 0;
    bit long_hold = 0;
    longint cycles = 0;

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sq(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    task automatic pair_up(input logic signed [15:0] x, y, z, input logic [15:0] w);
        longint unsigned lo2, hi2, d2, root, bin, s;
        int nd, act;
        lo2 = longint'(min_dist) * min_dist;
        hi2 = longint'(max_dist) * max_dist;
        nd = (dims == 0) ? 1 : dims;
        act = (bins_act > NUM_BINS) ? NUM_BINS : bins_act;
        for (int i = 0; i < pt_count; i++) begin
            d2 = sq(x, pt_x[i]);
            if (nd >= 2) d2 += sq(y, pt_y[i]);
            if (nd >= 3) d2 += sq(z, pt_z[i]);
            if (!(d2 > lo2 && d2 < hi2)) continue;
            root = isqrt(d2);
            if (root < min_dist) continue;
            bin = ((root - min_dist) * step_rec) >> 16;
            if (bin >= act) continue;
            s = hist[bin] + longint'(w) * pt_w[i];
            hist[bin] = (s > SUM_CAP) ? SUM_CAP : s;
        end
    endtask

    task automatic store_pt(input logic signed [15:0] x, y, z, input logic [15:0] w);
        if (pt_count < MAX_POINTS) begin
            pt_x[pt_count] = x;
            pt_y[pt_count] = y;
            pt_z[pt_count] = z;
            pt_w[pt_count] = w;
            pt_count++;
        end
    endtask

    task automatic predict_word(input t_row r);
        t_bin_word b;
        case (r.op)
            OP_CLEAR: begin
                pt_count = 0;
                foreach (hist[k]) hist[k] = 0;
            end
            OP_AUTO: begin
                pair_up(r.x, r.y, r.z, r.w);
                store_pt(r.x, r.y, r.z, r.w);
            end
            OP_REF: store_pt(r.x, r.y, r.z, r.w);
            OP_CROSS: pair_up(r.x, r.y, r.z, r.w);
            OP_DUMP: begin
                for (int k = 0; k < NUM_BINS; k++) begin
                    b.bin = k[4:0];
                    b.sum = r.zero_dump ? 48'd0 : hist[k][47:0];
                    b.last = (k == NUM_BINS - 1);
                    bins_due.push_back(b);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_row r);
        bit took;
        if (tx_idle > 0)
            while ($urandom_range(99) < tx_idle) @(negedge i_clk);
        i_valid = 1;
        i_operation = r.op;
        i_coord_x = r.x;
        i_coord_y = r.y;
        i_coord_z = r.z;
        i_point_weight = r.w;
        do begin
            @(posedge i_clk);
            took = o_ready;
        end while (!took);
        predict_word(r);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        case (idx)
            CFG_DIST_MIN: min_dist = data[16:0];
            CFG_DIST_MAX: max_dist = data[16:0];
            CFG_STEP_REC: step_rec = data;
            CFG_BINS:     bins_act = data[5:0];
            CFG_DIMS:     dims = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic wait_quiet();
        while (bins_due.size() != 0) @(posedge i_clk);
        repeat (pt_count + 64) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return 16'($signed($urandom_range(400)) - 200);
        return 16'($urandom);
    endfunction

    function automatic t_row rand_row();
        t_row r;
        int p;
        p = $urandom_range(99);
        if (p < 2)       r.op = OP_CLEAR;
        else if (p < 42) r.op = OP_AUTO;
        else if (p < 62) r.op = OP_REF;
        else if (p < 84) r.op = OP_CROSS;
        else if (p < 96) r.op = OP_DUMP;
        else             r.op = 3'($urandom_range(7, 5));
        r.x = rand_coord();
        r.y = rand_coord();
        r.z = rand_coord();
        r.w = ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom);
        r.zero_dump = 0;
        return r;
    endfunction

    // receiver: random backpressure, plus a long counted hold-off on request
    always @(negedge i_clk) begin
        if (long_hold) begin
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            wait (long_hold);
            repeat (400) @(posedge i_clk);
            @(negedge i_clk);
            long_hold = 0;
        end
    end

    always @(posedge i_clk) begin
        t_bin_word e;
        if (i_rst_n && o_valid && i_ready) begin
            if (bins_due.size() == 0) begin
                report($sformatf("unexpected bin word %0d", o_bin_number));
            end else begin
                e = bins_due.pop_front();
                if (o_bin_number !== e.bin)
                    report($sformatf("bin %0h want %0h", o_bin_number, e.bin));
                if (o_bin_sum !== e.sum)
                    report($sformatf("bin %0d sum %0h want %0h", e.bin, o_bin_sum, e.sum));
                if (o_last_bin !== e.last)
                    report($sformatf("bin %0d last %0b want %0b", e.bin, o_last_bin, e.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("weighted_pair_distance_histogram_top_tb: errors");
            $finish;
        end
    end

    t_row directed [] = '{
        '{OP_DUMP,  16'd0,     16'd0,     16'd0,     16'd0,     1},
        '{OP_AUTO,  16'd0,     16'd0,     16'd0,     16'hffff,  0},
        '{OP_AUTO,  16'd3,     16'd4,     16'd0,     16'hffff,  0},
        '{OP_AUTO,  16'h8000,  16'h8000,  16'h8000,  16'hffff,  0},
        '{OP_AUTO,  16'h7fff,  16'h7fff,  16'h7fff,  16'h0000,  0},
        '{OP_REF,   16'd10,    16'hfff0,  16'd7,     16'h1234,  0},
        '{OP_CROSS, 16'd1,     16'd1,     16'd1,     16'h8000,  0},
        '{OP_CROSS, 16'h7fff,  16'h8000,  16'h0000,  16'hffff,  0},
        '{3'd5,     16'hffff,  16'hffff,  16'hffff,  16'hffff,  0},
        '{3'd6,     16'd1,     16'd2,     16'd3,     16'd4,     0},
        '{3'd7,     16'd0,     16'd0,     16'd0,     16'd0,     0},
        '{OP_DUMP,  16'd0,     16'd0,     16'd0,     16'd0,     0},
        '{OP_CLEAR, 16'd0,     16'd0,     16'd0,     16'd0,     0},
        '{OP_DUMP,  16'd0,     16'd0,     16'd0,     16'd0,     1},
        '{OP_AUTO,  16'd5,     16'd5,     16'd5,     16'hffff,  0},
        '{OP_AUTO,  16'd6,     16'd5,     16'd5,     16'hffff,  0},
        '{OP_AUTO,  16'd5,     16'd9,     16'd5,     16'h0001,  0},
        '{OP_CROSS, 16'd5,     16'd5,     16'd30,    16'h00ff,  0},
        '{OP_DUMP,  16'd0,     16'd0,     16'd0,     16'd0,     0}
    };

    initial begin
        t_row r;
        foreach (hist[k]) hist[k] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        foreach (directed[k]) send_word(directed[k]);

        for (int ph = 0; ph < 6; ph++) begin
            wait_quiet();
            case (ph)
                0: begin
                    cfg_write(CFG_DIST_MIN, 24'd0);
                    cfg_write(CFG_DIST_MAX, 24'd600);
                    cfg_write(CFG_STEP_REC, 24'd3277);
                    cfg_write(CFG_BINS, 24'd32);
                    cfg_write(CFG_DIMS, 24'd3);
                    tx_idle = 30; rx_idle = 71;
                end
                1: begin
                    cfg_write(CFG_DIST_MIN, 24'($urandom_range(100)));
                    cfg_write(CFG_DIST_MAX, 24'($urandom_range(700, 200)));
                    cfg_write(CFG_STEP_REC, 24'($urandom_range(20000, 1000)));
                    cfg_write(CFG_BINS, 24'($urandom_range(63)) | 24'hffffc0);
                    cfg_write(CFG_DIMS, 24'd2 | 24'hfffff0);
                end
                2: begin
                    cfg_write(CFG_DIST_MIN, 24'h1ffff);
                    cfg_write(CFG_DIST_MAX, 24'd0);
                    cfg_write(CFG_STEP_REC, 24'hffffff);
                    cfg_write(CFG_BINS, 24'd0);
                    cfg_write(CFG_DIMS, 24'd0);
                    tx_idle = 71; rx_idle = 30;
                end
                3: begin
                    cfg_write(CFG_DIST_MIN, 24'd0);
                    cfg_write(CFG_DIST_MAX, 24'h1ffff);
                    cfg_write(CFG_STEP_REC, 24'd0);
                    cfg_write(CFG_BINS, 24'd1);
                    cfg_write(CFG_DIMS, 24'd1);
                end
                4: begin
                    cfg_write(CFG_DIST_MIN, 24'd20);
                    cfg_write(CFG_DIST_MAX, 24'd400);
                    cfg_write(CFG_STEP_REC, 24'hffffff);
                    cfg_write(CFG_BINS, 24'd63);
                    cfg_write(CFG_DIMS, 24'd3);
                    tx_idle = 0; rx_idle = 0;
                end
                default: begin
                    cfg_write(CFG_DIST_MIN, 24'd0);
                    cfg_write(CFG_DIST_MAX, 24'd2000);
                    cfg_write(CFG_STEP_REC, 24'd1000);
                    cfg_write(CFG_BINS, 24'd32);
                    cfg_write(CFG_DIMS, 24'd3);
                end
            endcase
            if (ph == 0) begin
                @(negedge i_clk);
                long_hold = 1;
                r = rand_row();
                r.op = OP_DUMP;
                repeat (4) send_word(r);
            end
            repeat (67) begin
                r = rand_row();
                if (r.op == OP_CLEAR || pt_count > 200) r.op = ($urandom_range(1)) ? OP_CLEAR
                                                                                    : OP_CROSS;
                send_word(r);
            end
        end

        while (bins_due.size() != 0) @(posedge i_clk);
        repeat (pt_count + 100) @(posedge i_clk);
        if (errors == 0) begin
            $display("weighted_pair_distance_histogram_top_tb: clean");
        end else begin
            $display("weighted_pair_distance_histogram_top_tb: errors");
        end
        $finish;
    end
endmodule
